// ===== rtl/papl_pkg.sv =====
package papl_pkg;

    localparam int PAIRS_PER_BUFFER = 1152;
    localparam int POS_W  = (PAIRS_PER_BUFFER > 1) ? $clog2(PAIRS_PER_BUFFER) : 1;
    localparam int DEPTH  = 2 * PAIRS_PER_BUFFER;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [1:0] {
        CFG_DAC_OFFSET = 2'd0,
        CFG_DAC_GAIN   = 2'd1,
        CFG_DAC_SHIFT  = 2'd2,
        CFG_PWM_PERIOD = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic write_accepted;
        logic underflow;
        logic sample_valid;
    } t_flags;

    typedef struct packed {
        logic signed [31:0] dac_offset;
        logic [15:0]        dac_gain;
        logic [4:0]         dac_shift;
        logic [15:0]        pwm_period;
    } t_cfg;

endpackage

// ===== rtl/papl_store.sv =====
module papl_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_in_valid,
    input  logic                 i_operation,
    input  logic signed [15:0]   i_left_sample,
    input  logic signed [15:0]   i_right_sample,
    output papl_pkg::t_flags     o_flags,
    output logic [31:0]          o_pair
);

    logic [31:0] mem [papl_pkg::DEPTH];

    logic [1:0]                 r_full, n_full;
    logic                       r_wsel, n_wsel;
    logic                       r_rsel, n_rsel;
    logic [papl_pkg::POS_W-1:0] r_wpos, n_wpos;
    logic [papl_pkg::POS_W-1:0] r_rpos, n_rpos;
    papl_pkg::t_flags           r_flags, n_flags;
    logic [31:0]                r_pair;

    logic                        accept;
    logic                        do_write;
    logic                        do_read;
    logic [papl_pkg::ADDR_W-1:0] waddr;
    logic [papl_pkg::ADDR_W-1:0] raddr;

    localparam logic [papl_pkg::POS_W-1:0] LAST_POS =
        papl_pkg::POS_W'(papl_pkg::PAIRS_PER_BUFFER - 1);
    localparam logic [papl_pkg::ADDR_W-1:0] BASE1 =
        papl_pkg::ADDR_W'(papl_pkg::PAIRS_PER_BUFFER);

    assign accept   = i_in_valid && i_en;
    assign do_write = accept && (i_operation == papl_pkg::OP_WRITE) && !r_full[r_wsel];
    assign do_read  = accept && (i_operation == papl_pkg::OP_TICK) && r_full[r_rsel];

    assign waddr = (r_wsel ? BASE1 : '0) + papl_pkg::ADDR_W'(r_wpos);
    assign raddr = (r_rsel ? BASE1 : '0) + papl_pkg::ADDR_W'(r_rpos);

    always_comb begin
        n_full  = r_full;
        n_wsel  = r_wsel;
        n_rsel  = r_rsel;
        n_wpos  = r_wpos;
        n_rpos  = r_rpos;
        n_flags = r_flags;
        if (do_write) begin
            if (r_wpos == LAST_POS) begin
                n_wpos         = '0;
                n_full[r_wsel] = 1'b1;
                n_wsel         = ~r_wsel;
            end else begin
                n_wpos = r_wpos + 1'b1;
            end
        end
        if (do_read) begin
            if (r_rpos == LAST_POS) begin
                n_rpos         = '0;
                n_full[r_rsel] = 1'b0;
                n_rsel         = ~r_rsel;
            end else begin
                n_rpos = r_rpos + 1'b1;
            end
        end
        if (i_en) begin
            n_flags.valid          = accept;
            n_flags.write_accepted = do_write;
            n_flags.underflow      = accept && (i_operation == papl_pkg::OP_TICK)
                                     && !r_full[r_rsel];
            n_flags.sample_valid   = do_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full  <= '0;
            r_wsel  <= 1'b0;
            r_rsel  <= 1'b0;
            r_wpos  <= '0;
            r_rpos  <= '0;
            r_flags <= '0;
        end else begin
            r_full  <= n_full;
            r_wsel  <= n_wsel;
            r_rsel  <= n_rsel;
            r_wpos  <= n_wpos;
            r_rpos  <= n_rpos;
            r_flags <= n_flags;
        end
    end

    // right sample in the high half, left in the low half
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[waddr] <= {i_right_sample, i_left_sample};
        end
        if (do_read) begin
            r_pair <= mem[raddr];
        end
    end

    assign o_flags = r_flags;
    assign o_pair  = r_pair;

    // exactly one buffer full: reader sits on it, writer on the other one
    a_one_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full == 2'b01 || r_full == 2'b10) |-> (r_full[r_rsel] && !r_full[r_wsel]))
        else $error("read/write select disagrees with single full buffer");

    a_sel_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full == 2'b00 || r_full == 2'b11) |-> (r_wsel == r_rsel))
        else $error("selects diverged while both buffers share a state");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wpos <= LAST_POS) && (r_rpos <= LAST_POS))
        else $error("buffer position out of range");

endmodule

// ===== rtl/papl_scale.sv =====
module papl_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  papl_pkg::t_flags   i_flags,
    input  logic [31:0]        i_pair,
    input  papl_pkg::t_cfg     i_cfg,
    output papl_pkg::t_flags   o_flags,
    output logic [11:0]        o_dac_left,
    output logic [11:0]        o_dac_right,
    output logic [15:0]        o_pwm_left,
    output logic [15:0]        o_pwm_right
);

    papl_pkg::t_flags   r_flags;
    logic signed [32:0] r_prod_l, r_prod_r;
    logic [31:0]        r_pwm_l, r_pwm_r;

    logic signed [32:0] n_prod_l, n_prod_r;
    logic [31:0]        n_pwm_l, n_pwm_r;
    logic signed [16:0] gain_s;
    logic signed [33:0] sum_l, sum_r;
    logic signed [33:0] sh_l, sh_r;

    assign gain_s   = $signed({1'b0, i_cfg.dac_gain});
    assign n_prod_l = gain_s * $signed(i_pair[15:0]);
    assign n_prod_r = gain_s * $signed(i_pair[31:16]);
    // sample + 32768 is the sample with its sign bit flipped
    assign n_pwm_l  = {i_pair[15] ^ 1'b1, i_pair[14:0]} * i_cfg.pwm_period;
    assign n_pwm_r  = {i_pair[31] ^ 1'b1, i_pair[30:16]} * i_cfg.pwm_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_en) begin
            r_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_l <= n_prod_l;
            r_prod_r <= n_prod_r;
            r_pwm_l  <= n_pwm_l;
            r_pwm_r  <= n_pwm_r;
        end
    end

    assign sum_l = 34'(i_cfg.dac_offset) + 34'(r_prod_l);
    assign sum_r = 34'(i_cfg.dac_offset) + 34'(r_prod_r);
    assign sh_l  = sum_l >>> i_cfg.dac_shift;
    assign sh_r  = sum_r >>> i_cfg.dac_shift;

    assign o_flags     = r_flags;
    assign o_dac_left  = r_flags.sample_valid ? sh_l[11:0] : '0;
    assign o_dac_right = r_flags.sample_valid ? sh_r[11:0] : '0;
    assign o_pwm_left  = r_flags.sample_valid ? r_pwm_l[31:16] : '0;
    assign o_pwm_right = r_flags.sample_valid ? r_pwm_r[31:16] : '0;

endmodule

// ===== rtl/pingpong_audio_sample_player.sv =====
// Ping-pong stereo sample player.
// Input channel (i_in_valid / o_in_ready): operation 0 stores one left/right
// pair into the current write buffer (refused while that buffer is full);
// operation 1 is a playback tick that plays the next pair of the full read
// buffer or reports underflow. Every request yields exactly one result on the
// output channel (o_out_valid / i_out_ready).
// A result is registered in the store read, the multiply stage and the output
// register, in that order, after its request is accepted. Throughput is one
// request per cycle while the receiver does not stall: the sample store has
// one write and one read port and each request uses at most one of them.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
// once; change them only while the block is idle.
// Reset empties both buffers, points reader and writer at buffer zero and
// loads the register defaults (pwm_period 1, others 0). Store contents are
// not cleared; no entry is read before it has been written.
// When the receiver stalls, the whole pipeline holds and o_in_ready drops
// until the waiting result is taken.
module pingpong_audio_sample_player (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic signed [15:0] i_left_sample,
    input  logic signed [15:0] i_right_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_write_accepted,
    output logic               o_underflow,
    output logic               o_sample_valid,
    output logic [11:0]        o_dac_left,
    output logic [11:0]        o_dac_right,
    output logic [15:0]        o_pwm_left,
    output logic [15:0]        o_pwm_right
);

    papl_pkg::t_cfg   r_cfg;
    papl_pkg::t_flags s1_flags, s2_flags;
    logic [31:0]      s1_pair;
    logic [11:0]      s2_dac_l, s2_dac_r;
    logic [15:0]      s2_pwm_l, s2_pwm_r;
    logic             en;

    logic             r_out_valid;
    logic             r_write_accepted, r_underflow, r_sample_valid;
    logic [11:0]      r_dac_left, r_dac_right;
    logic [15:0]      r_pwm_left, r_pwm_right;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dac_offset <= '0;
            r_cfg.dac_gain   <= '0;
            r_cfg.dac_shift  <= '0;
            r_cfg.pwm_period <= 16'd1;
        end else if (i_cfg_we) begin
            case (papl_pkg::t_cfg_idx'(i_cfg_index))
                papl_pkg::CFG_DAC_OFFSET: r_cfg.dac_offset <= $signed(i_cfg_data);
                papl_pkg::CFG_DAC_GAIN:   r_cfg.dac_gain   <= i_cfg_data[15:0];
                papl_pkg::CFG_DAC_SHIFT:  r_cfg.dac_shift  <= i_cfg_data[4:0];
                papl_pkg::CFG_PWM_PERIOD: r_cfg.pwm_period <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    papl_store u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_in_valid     (i_in_valid),
        .i_operation    (i_operation),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_flags        (s1_flags),
        .o_pair         (s1_pair)
    );

    papl_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_flags     (s1_flags),
        .i_pair      (s1_pair),
        .i_cfg       (r_cfg),
        .o_flags     (s2_flags),
        .o_dac_left  (s2_dac_l),
        .o_dac_right (s2_dac_r),
        .o_pwm_left  (s2_pwm_l),
        .o_pwm_right (s2_pwm_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s2_flags.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_write_accepted <= s2_flags.write_accepted;
            r_underflow      <= s2_flags.underflow;
            r_sample_valid   <= s2_flags.sample_valid;
            r_dac_left       <= s2_dac_l;
            r_dac_right      <= s2_dac_r;
            r_pwm_left       <= s2_pwm_l;
            r_pwm_right      <= s2_pwm_r;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_write_accepted = r_write_accepted;
    assign o_underflow      = r_underflow;
    assign o_sample_valid   = r_sample_valid;
    assign o_dac_left       = r_dac_left;
    assign o_dac_right      = r_dac_right;
    assign o_pwm_left       = r_pwm_left;
    assign o_pwm_right      = r_pwm_right;

    // a result is a write, an underflow, a played pair, or a refused write
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_write_accepted, o_underflow, o_sample_valid}))
        else $error("result carries more than one outcome");

endmodule
